// ===== rtl/bsr_pkg.sv =====
// Shared types, codes and masks for the branch and status register execute block.
`default_nettype none
package bsr_pkg;

   localparam logic [31:0] MASK_UNALLOC = 32'h06FF_FF00;
   localparam logic [31:0] MASK_USER    = 32'hF800_0000;
   localparam logic [31:0] MASK_PRIV    = 32'h0000_000F;
   localparam logic [31:0] MASK_STATE   = 32'h0100_0020;
   localparam logic [31:0] T_BIT        = 32'h0000_0020;
   localparam logic [31:0] PC_ALIGN     = 32'hFFFF_FFFE;
   localparam logic [31:0] BYTE0        = 32'h0000_00FF;
   localparam logic [31:0] BYTE1        = 32'h0000_FF00;
   localparam logic [31:0] BYTE2        = 32'h00FF_0000;
   localparam logic [31:0] BYTE3        = 32'hFF00_0000;
   localparam logic [31:0] LINK_OFFSET  = 32'd4;

   localparam logic [4:0] MODE_USR = 5'h10;
   localparam logic [4:0] MODE_SYS = 5'h1F;

   localparam logic ACTION_BRANCH = 1'b0;
   localparam logic ACTION_MISC   = 1'b1;

   // opcode fields of the miscellaneous class
   localparam logic [7:0] OP_BX_GROUP  = 8'h12;
   localparam logic [3:0] OP_BLX_REG   = 4'h3;
   localparam logic [4:0] OP_PSR_REG   = 5'b00010;
   localparam logic [4:0] OP_MSR_IMM   = 5'b00110;
   localparam logic [1:0] OP_MRS_LOW   = 2'b00;
   localparam logic [1:0] OP_MSR_LOW   = 2'b10;
   localparam logic [3:0] OP_MSR_SHIFT = 4'h0;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_UNDEF = 2'd1,
      STATUS_THUMB = 2'd2
   } status_type;

   typedef struct packed {
      logic        action;
      logic [31:0] instruction;
      logic [31:0] pc_now;
      logic [31:0] rm_value;
      logic [31:0] cpsr_now;
      logic [31:0] spsr_now;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        pc_write;
      logic [31:0] pc_next;
      logic        lr_write;
      logic [31:0] lr_value;
      logic        rd_write;
      logic [3:0]  rd_index;
      logic [31:0] rd_value;
      logic        cpsr_write;
      logic [31:0] cpsr_next;
      logic        spsr_write;
      logic [31:0] spsr_next;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/bsr_exec.sv =====
// Decode and result logic for one instruction, between the input and result registers.
`default_nettype none
module bsr_exec (
   input  var bsr_pkg::req_type req,
   output bsr_pkg::rsp_type     rsp
);

   logic [31:0] ins;
   logic [31:0] branch_offset;
   logic [31:0] link_addr;
   logic [63:0] imm_pair;
   logic [4:0]  imm_rot;
   logic [31:0] imm_op;
   logic [31:0] msr_op;
   logic [31:0] bytes;
   logic [31:0] mask;
   logic [4:0]  mode;
   logic        is_blx;
   logic        is_mrs;
   logic        is_msr_imm;
   logic        is_msr_reg;

   assign ins           = req.instruction;
   assign mode          = req.cpsr_now[4:0];
   assign branch_offset = {{6{ins[23]}}, ins[23:0], 2'b00};
   assign link_addr     = req.pc_now - bsr_pkg::LINK_OFFSET;

   assign imm_rot  = {ins[11:8], 1'b0};
   assign imm_pair = {24'd0, ins[7:0], 24'd0, ins[7:0]} >> imm_rot;
   assign imm_op   = imm_pair[31:0];

   assign is_blx     = (ins[27:20] == bsr_pkg::OP_BX_GROUP) && (ins[7:4] == bsr_pkg::OP_BLX_REG);
   assign is_mrs     = (ins[27:23] == bsr_pkg::OP_PSR_REG) && (ins[21:20] == bsr_pkg::OP_MRS_LOW);
   assign is_msr_imm = (ins[27:23] == bsr_pkg::OP_MSR_IMM) && (ins[21:20] == bsr_pkg::OP_MSR_LOW);
   assign is_msr_reg = (ins[27:23] == bsr_pkg::OP_PSR_REG) && (ins[21:20] == bsr_pkg::OP_MSR_LOW)
                       && (ins[7:4] == bsr_pkg::OP_MSR_SHIFT);

   assign msr_op = is_msr_imm ? imm_op : req.rm_value;
   assign bytes  = (ins[16] ? bsr_pkg::BYTE0 : 32'd0) | (ins[17] ? bsr_pkg::BYTE1 : 32'd0) |
                   (ins[18] ? bsr_pkg::BYTE2 : 32'd0) | (ins[19] ? bsr_pkg::BYTE3 : 32'd0);

   always_comb begin
      if (ins[22]) begin
         mask = bytes & (bsr_pkg::MASK_USER | bsr_pkg::MASK_PRIV | bsr_pkg::MASK_STATE);
      end else if (mode == bsr_pkg::MODE_USR) begin
         mask = bytes & bsr_pkg::MASK_USER;
      end else if ((msr_op & bsr_pkg::MASK_STATE) == 32'd0) begin
         mask = bytes & (bsr_pkg::MASK_USER | bsr_pkg::MASK_PRIV);
      end else begin
         mask = 32'd0;
      end
   end

   always_comb begin
      rsp = '0;
      rsp.status = bsr_pkg::STATUS_OK;
      if (req.action == bsr_pkg::ACTION_BRANCH) begin
         rsp.pc_write = 1'b1;
         rsp.pc_next  = req.pc_now + branch_offset;
         rsp.lr_write = ins[24];
         rsp.lr_value = ins[24] ? link_addr : 32'd0;
      end else begin
         priority if (is_blx) begin
            if (req.rm_value[0]) begin
               rsp.status = bsr_pkg::STATUS_THUMB;
            end else begin
               rsp.pc_write   = 1'b1;
               rsp.pc_next    = req.rm_value & bsr_pkg::PC_ALIGN;
               rsp.lr_write   = 1'b1;
               rsp.lr_value   = link_addr;
               rsp.cpsr_write = 1'b1;
               rsp.cpsr_next  = req.cpsr_now & ~bsr_pkg::T_BIT;
            end
         end else if (is_mrs) begin
            rsp.rd_write = 1'b1;
            rsp.rd_index = ins[15:12];
            rsp.rd_value = ins[22] ? req.spsr_now : req.cpsr_now;
         end else if (is_msr_imm || is_msr_reg) begin
            // an operand touching unallocated bits writes nothing
            if ((msr_op & bsr_pkg::MASK_UNALLOC) == 32'd0) begin
               if (!ins[22]) begin
                  rsp.cpsr_write = 1'b1;
                  rsp.cpsr_next  = (req.cpsr_now & ~mask) | (msr_op & mask);
               end else if ((mode != bsr_pkg::MODE_USR) && (mode != bsr_pkg::MODE_SYS)) begin
                  rsp.spsr_write = 1'b1;
                  rsp.spsr_next  = (req.spsr_now & ~mask) | (msr_op & mask);
               end
            end
         end else begin
            rsp.status = bsr_pkg::STATUS_UNDEF;
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/branch_and_status_register_execute.sv =====
// Top level of the branch and status register execute block: input and result registers.
//
//   channel | ports  | direction | payload
//   --------+--------+-----------+--------------------------------------------
//   request | req_*  | in        | action, instruction, pc_now, rm_value, psrs
//   result  | rsp_*  | out       | status and the pc/lr/rd/cpsr/spsr writes
//
// One transfer in per cycle while rsp_stall is low; rsp_valid rises once the
// request has passed the input and then the result register, with decode in between.
// Reset (synchronous, active high) clears both stage valid bits only.
// rsp_stall holds the result register; the input stage keeps accepting while
// the result stage is free or draining, so req_stall rises only when both are full.
`default_nettype none
module branch_and_status_register_execute (
   input  var logic        clock,
   input  var logic        reset,

   input  var logic        req_valid,
   output logic            req_stall,
   input  var logic        req_action,
   input  var logic [31:0] req_instruction,
   input  var logic [31:0] req_pc_now,
   input  var logic [31:0] req_rm_value,
   input  var logic [31:0] req_cpsr_now,
   input  var logic [31:0] req_spsr_now,

   output logic            rsp_valid,
   input  var logic        rsp_stall,
   output logic [1:0]      rsp_status,
   output logic            rsp_pc_write,
   output logic [31:0]     rsp_pc_next,
   output logic            rsp_lr_write,
   output logic [31:0]     rsp_lr_value,
   output logic            rsp_rd_write,
   output logic [3:0]      rsp_rd_index,
   output logic [31:0]     rsp_rd_value,
   output logic            rsp_cpsr_write,
   output logic [31:0]     rsp_cpsr_next,
   output logic            rsp_spsr_write,
   output logic [31:0]     rsp_spsr_next
);

   // input stage
   logic              in_valid_ff;
   bsr_pkg::req_type  in_data_ff;
   bsr_pkg::req_type  in_data_in;

   // result stage
   logic              out_valid_ff;
   bsr_pkg::rsp_type  out_data_ff;
   bsr_pkg::rsp_type  out_data_in;

   logic              out_free;
   logic              advance;
   logic              in_load;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign in_load   = !in_valid_ff || advance;
   assign req_stall = !in_load;

   assign in_data_in = '{
      action:      req_action,
      instruction: req_instruction,
      pc_now:      req_pc_now,
      rm_value:    req_rm_value,
      cpsr_now:    req_cpsr_now,
      spsr_now:    req_spsr_now
   };

   bsr_exec u_exec (
      .req (in_data_ff),
      .rsp (out_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_load) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_data_ff <= in_data_in;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_data_ff.status;
   assign rsp_pc_write   = out_data_ff.pc_write;
   assign rsp_pc_next    = out_data_ff.pc_next;
   assign rsp_lr_write   = out_data_ff.lr_write;
   assign rsp_lr_value   = out_data_ff.lr_value;
   assign rsp_rd_write   = out_data_ff.rd_write;
   assign rsp_rd_index   = out_data_ff.rd_index;
   assign rsp_rd_value   = out_data_ff.rd_value;
   assign rsp_cpsr_write = out_data_ff.cpsr_write;
   assign rsp_cpsr_next  = out_data_ff.cpsr_next;
   assign rsp_spsr_write = out_data_ff.spsr_write;
   assign rsp_spsr_next  = out_data_ff.spsr_next;

endmodule
`default_nettype wire

// ===== rtl/bsr_checker.sv =====
// Port-level checks for the branch and status register execute block, with its bind.
`default_nettype none
module bsr_checker (
   input var logic        clock,
   input var logic        reset,
   input var logic        rsp_valid,
   input var logic        rsp_stall,
   input var logic [1:0]  rsp_status,
   input var logic        rsp_pc_write,
   input var logic [31:0] rsp_pc_next,
   input var logic        rsp_lr_write,
   input var logic [31:0] rsp_lr_value,
   input var logic        rsp_rd_write,
   input var logic [3:0]  rsp_rd_index,
   input var logic [31:0] rsp_rd_value,
   input var logic        rsp_cpsr_write,
   input var logic [31:0] rsp_cpsr_next,
   input var logic        rsp_spsr_write,
   input var logic [31:0] rsp_spsr_next
);

   // no result survives a reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a fault writes nothing
   a_fault_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != bsr_pkg::STATUS_OK)) |->
      !(rsp_pc_write || rsp_lr_write || rsp_rd_write || rsp_cpsr_write || rsp_spsr_write))
      else $error("write flag set on faulting result");

   // value fields are zero when their write flag is clear
   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
      ((rsp_pc_write || rsp_pc_next == 32'd0) && (rsp_lr_write || rsp_lr_value == 32'd0) &&
       (rsp_rd_write || (rsp_rd_index == 4'd0 && rsp_rd_value == 32'd0)) &&
       (rsp_cpsr_write || rsp_cpsr_next == 32'd0) &&
       (rsp_spsr_write || rsp_spsr_next == 32'd0)))
      else $error("nonzero value without write flag");

   // stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(rsp_status) && $stable(rsp_pc_next) && $stable(rsp_lr_value) &&
       $stable(rsp_rd_value) && $stable(rsp_cpsr_next) && $stable(rsp_spsr_next)))
      else $error("stalled result changed");

endmodule

bind branch_and_status_register_execute bsr_checker u_bsr_checker (.*);
`default_nettype wire

// ===== bench/branch_and_status_register_execute_tb.sv =====
// Self-checking bench for the branch and status register execute block.
`timescale 1ns / 100ps
module branch_and_status_register_execute_tb;

   // Worst case per transfer is roughly the longest send gap plus the longest
   // result stall, so ~625 transfers stay far below this.
   localparam int CYCLE_LIMIT = 400000;
   // Two register stages between request and result; wait a few more.
   localparam int DRAIN_TAIL  = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic        req_action      = 1'b0;
   logic [31:0] req_instruction = '0;
   logic [31:0] req_pc_now      = '0;
   logic [31:0] req_rm_value    = '0;
   logic [31:0] req_cpsr_now    = '0;
   logic [31:0] req_spsr_now    = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_pc_write;
   logic [31:0] rsp_pc_next;
   logic        rsp_lr_write;
   logic [31:0] rsp_lr_value;
   logic        rsp_rd_write;
   logic [3:0]  rsp_rd_index;
   logic [31:0] rsp_rd_value;
   logic        rsp_cpsr_write;
   logic [31:0] rsp_cpsr_next;
   logic        rsp_spsr_write;
   logic [31:0] rsp_spsr_next;

   // Results predicted for accepted requests, oldest first.
   bsr_pkg::rsp_type expected_results[$];

   int mismatches  = 0;
   int cycle_count = 0;

   // Idle percentages; the directed tests share one mix, each random block sets its own.
   int send_gap_pct = 0;
   int stall_pct    = 0;
   int stall_hold   = 0;

   // What the run exercised, counted on the predicted writes.
   int n_transfers = 0;
   int n_pc_writes = 0;
   int n_rd_writes = 0;
   int n_cpsr      = 0;
   int n_spsr      = 0;
   int n_undef     = 0;
   int n_thumb     = 0;

   branch_and_status_register_execute dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_instruction(req_instruction),
      .req_pc_now     (req_pc_now),
      .req_rm_value   (req_rm_value),
      .req_cpsr_now   (req_cpsr_now),
      .req_spsr_now   (req_spsr_now),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_pc_write   (rsp_pc_write),
      .rsp_pc_next    (rsp_pc_next),
      .rsp_lr_write   (rsp_lr_write),
      .rsp_lr_value   (rsp_lr_value),
      .rsp_rd_write   (rsp_rd_write),
      .rsp_rd_index   (rsp_rd_index),
      .rsp_rd_value   (rsp_rd_value),
      .rsp_cpsr_write (rsp_cpsr_write),
      .rsp_cpsr_next  (rsp_cpsr_next),
      .rsp_spsr_write (rsp_spsr_write),
      .rsp_spsr_next  (rsp_spsr_next)
   );

   always #6 clock = ~clock;

   // Run guard: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("branch_and_status_register_execute regression: fail");
         $finish;
      end
   end

   // Decode and execute one request; every field that is not written is zero.
   function automatic bsr_pkg::rsp_type predict_result(input bsr_pkg::req_type r);
      bsr_pkg::rsp_type e;
      logic [31:0]      ins, op, imm, fields, mask, offset;
      logic [63:0]      rotated;
      logic [4:0]       mode;
      logic             is_msr;
      ins    = r.instruction;
      mode   = r.cpsr_now[4:0];
      e      = '0;
      is_msr = 1'b0;
      op     = '0;
      mask   = '0;
      if (r.action == bsr_pkg::ACTION_BRANCH) begin
         // B/BL: signed word offset, link holds the address after the branch
         offset     = {{8{ins[23]}}, ins[23:0]};
         e.pc_write = 1'b1;
         e.pc_next  = r.pc_now + (offset << 2);
         e.lr_write = ins[24];
         e.lr_value = ins[24] ? r.pc_now - bsr_pkg::LINK_OFFSET : '0;
      end else if (ins[27:20] == bsr_pkg::OP_BX_GROUP && ins[7:4] == bsr_pkg::OP_BLX_REG) begin
         // BLX register: odd target would switch to Thumb, not supported
         if (r.rm_value[0]) begin
            e.status = bsr_pkg::STATUS_THUMB;
         end else begin
            e.pc_write   = 1'b1;
            e.pc_next    = r.rm_value & bsr_pkg::PC_ALIGN;
            e.lr_write   = 1'b1;
            e.lr_value   = r.pc_now - bsr_pkg::LINK_OFFSET;
            e.cpsr_write = 1'b1;
            e.cpsr_next  = r.cpsr_now & ~bsr_pkg::T_BIT;
         end
      end else if (ins[27:23] == bsr_pkg::OP_PSR_REG && ins[21:20] == bsr_pkg::OP_MRS_LOW) begin
         e.rd_write = 1'b1;
         e.rd_index = ins[15:12];
         e.rd_value = ins[22] ? r.spsr_now : r.cpsr_now;
      end else if (ins[27:23] == bsr_pkg::OP_MSR_IMM && ins[21:20] == bsr_pkg::OP_MSR_LOW) begin
         // 8-bit immediate rotated right by twice the rotate field
         imm     = {24'b0, ins[7:0]};
         rotated = {imm, imm} >> {ins[11:8], 1'b0};
         op      = rotated[31:0];
         is_msr  = 1'b1;
      end else if (ins[27:23] == bsr_pkg::OP_PSR_REG && ins[21:20] == bsr_pkg::OP_MSR_LOW
                   && ins[7:4] == bsr_pkg::OP_MSR_SHIFT) begin
         op     = r.rm_value;
         is_msr = 1'b1;
      end else begin
         e.status = bsr_pkg::STATUS_UNDEF;
      end

      // MSR: an operand touching unallocated bits writes nothing at all
      if (is_msr && (op & bsr_pkg::MASK_UNALLOC) == '0) begin
         fields = {{8{ins[19]}}, {8{ins[18]}}, {8{ins[17]}}, {8{ins[16]}}};
         if (!ins[22]) begin
            if (mode == bsr_pkg::MODE_USR)
               mask = fields & bsr_pkg::MASK_USER;
            else if ((op & bsr_pkg::MASK_STATE) == '0)
               mask = fields & (bsr_pkg::MASK_USER | bsr_pkg::MASK_PRIV);
            e.cpsr_write = 1'b1;
            e.cpsr_next  = (r.cpsr_now & ~mask) | (op & mask);
         end else if (mode != bsr_pkg::MODE_USR && mode != bsr_pkg::MODE_SYS) begin
            mask         = fields & (bsr_pkg::MASK_USER | bsr_pkg::MASK_PRIV |
                                     bsr_pkg::MASK_STATE);
            e.spsr_write = 1'b1;
            e.spsr_next  = (r.spsr_now & ~mask) | (op & mask);
         end
      end
      return e;
   endfunction

   function automatic bsr_pkg::req_type make_req(input logic action, input logic [31:0] ins,
                                                 input logic [31:0] pc,
                                                 input logic [31:0] rm,
                                                 input logic [31:0] cpsr,
                                                 input logic [31:0] spsr);
      bsr_pkg::req_type r;
      r.action      = action;
      r.instruction = ins;
      r.pc_now      = pc;
      r.rm_value    = rm;
      r.cpsr_now    = cpsr;
      r.spsr_now    = spsr;
      return r;
   endfunction

   // Drive one request until transfer, record its result, then maybe idle.
   task automatic send_item(input bsr_pkg::req_type item);
      bsr_pkg::rsp_type predicted;
      int               gap;
      req_valid       <= 1'b1;
      req_action      <= item.action;
      req_instruction <= item.instruction;
      req_pc_now      <= item.pc_now;
      req_rm_value    <= item.rm_value;
      req_cpsr_now    <= item.cpsr_now;
      req_spsr_now    <= item.spsr_now;
      do @(posedge clock); while (req_stall !== 1'b0);

      predicted = predict_result(item);
      expected_results.push_back(predicted);
      n_transfers++;
      n_pc_writes += int'(predicted.pc_write);
      n_rd_writes += int'(predicted.rd_write);
      n_cpsr      += int'(predicted.cpsr_write);
      n_spsr      += int'(predicted.spsr_write);
      n_undef     += int'(predicted.status == bsr_pkg::STATUS_UNDEF);
      n_thumb     += int'(predicted.status == bsr_pkg::STATUS_THUMB);

      // mostly back to back or short gaps, now and then a long one
      gap = 0;
      if ($urandom_range(99) < send_gap_pct)
         gap = ($urandom_range(4) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 1);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Sender holds off until every outstanding result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endtask

   // Result side: random stall bursts, mostly short, some long, some none.
   always @(posedge clock) begin
      if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else if ($urandom_range(99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_hold <= ($urandom_range(5) == 0) ? $urandom_range(30, 8) : $urandom_range(2);
      end else begin
         rsp_stall  <= 1'b0;
         stall_hold <= $urandom_range(6);
      end
   end

   // Every result transfer is compared against the oldest prediction.
   always @(posedge clock) begin
      bsr_pkg::rsp_type want;
      if (!reset && $isunknown(rsp_valid)) begin
         $error("rsp_valid unknown");
         mismatches++;
      end
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with no request outstanding");
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            check_field("status",     32'(want.status),     32'(rsp_status));
            check_field("pc_write",   32'(want.pc_write),   32'(rsp_pc_write));
            check_field("pc_next",    want.pc_next,         rsp_pc_next);
            check_field("lr_write",   32'(want.lr_write),   32'(rsp_lr_write));
            check_field("lr_value",   want.lr_value,        rsp_lr_value);
            check_field("rd_write",   32'(want.rd_write),   32'(rsp_rd_write));
            check_field("rd_index",   32'(want.rd_index),   32'(rsp_rd_index));
            check_field("rd_value",   want.rd_value,        rsp_rd_value);
            check_field("cpsr_write", 32'(want.cpsr_write), 32'(rsp_cpsr_write));
            check_field("cpsr_next",  want.cpsr_next,       rsp_cpsr_next);
            check_field("spsr_write", 32'(want.spsr_write), 32'(rsp_spsr_write));
            check_field("spsr_next",  want.spsr_next,       rsp_spsr_next);
         end
      end
   end

   // B and BL: offset extremes, PC wrap, link on and off.
   task automatic test_branches();
      send_item(make_req(bsr_pkg::ACTION_BRANCH, 32'hEA00_0000, 32'h0000_0000, '0,
                         32'h0000_00D3, '0));
      send_item(make_req(bsr_pkg::ACTION_BRANCH, 32'hEA7F_FFFF, 32'hFFFF_FFF8, '0,
                         32'h0000_0010, '0));
      send_item(make_req(bsr_pkg::ACTION_BRANCH, 32'hEB80_0000, 32'h0000_0000, '0,
                         32'h0000_0013, '0));
      send_item(make_req(bsr_pkg::ACTION_BRANCH, 32'hEBFF_FFFF, 32'h0000_0008, '0,
                         32'h0000_001F, '0));
      // a word that would be undefined in the other class is still a branch
      send_item(make_req(bsr_pkg::ACTION_BRANCH, 32'hFFFF_FFFF, 32'h8000_0000, '1, '1, '1));
   endtask

   // BLX register: even target, odd target (Thumb reject), BLX LR.
   task automatic test_blx();
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'hE12F_FF33, 32'h0000_1008, 32'hFFFF_FFFE,
                         32'h0000_0030, '0));
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'hE12F_FF33, 32'h0000_1008, 32'h0000_0001,
                         32'h0000_00D3, '0));
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'hE12F_FF3E, 32'h0000_0004, 32'h0000_8000,
                         32'hFFFF_FFFF, '0));
   endtask

   // MRS from CPSR into Rd 1 and from SPSR into the highest Rd.
   task automatic test_mrs();
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'hE10F_1000, '0, '0, 32'hA000_00D3,
                         32'h1234_5678));
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'hE14F_F000, '0, '0, 32'h0000_0010,
                         32'hFFFF_FFFF));
   endtask

   // MSR to CPSR: privileged and user masks, state bit, unallocated bit.
   task automatic test_msr_cpsr();
      // immediate 0xF8 ror 4 = 0x8000000F, all fields
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'hE32F_F2F8, '0, '0, 32'h0000_00D3, '0));
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'hE32F_F2F8, '0, '0, 32'h0000_0010, '0));
      // state bit in the operand empties the privileged mask
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'hE32F_F020, '0, '0, 32'hFFFF_FFD3, '0));
      // 0xFF ror 24 lands on unallocated bits: nothing written
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'hE32F_FCFF, '0, '0, 32'h0000_00D3, '0));
      // no field bits selected
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'hE320_F2F8, '0, '0, 32'h0000_00D3, '0));
      // register form, fields f and c
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'hE129_F002, '0, 32'h0100_0000,
                         32'h0000_0013, '0));
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'hE129_F002, '0, 32'hF800_00DF,
                         32'h0000_0010, '0));
   endtask

   // MSR to SPSR: modes with and without an SPSR, odd mode code.
   task automatic test_msr_spsr();
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'hE36F_F2F8, '0, '0, 32'h0000_0012,
                         32'h0FFF_FFF0));
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'hE36F_F2F8, '0, '0, 32'h0000_001F,
                         32'h0FFF_FFF0));
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'hE36F_F2F8, '0, '0, 32'h0000_0010,
                         32'h0FFF_FFF0));
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'hE36F_F2F8, '0, '0, 32'h0000_0005,
                         32'h0FFF_FFF0));
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'hE16F_F001, '0, 32'h0100_0020,
                         32'h0000_0011, '0));
   endtask

   // Miscellaneous-class words that match no pattern.
   task automatic test_undefined();
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'hE129_F012, '0, '0, '0, '0));
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'hFFFF_FFFF, '1, '1, '1, '1));
      send_item(make_req(bsr_pkg::ACTION_MISC, 32'h0000_0000, '0, '0, '0, '0));
   endtask

   // Mostly well-formed words with random content, some noise. Phases vary
   // the idling, one runs with none, and the sender drains twice midway.
   task automatic test_random_mix(input int blocks, input int per_block);
      int               gap_levels[6]   = '{0, 35, 10, 60, 20, 45};
      int               stall_levels[6] = '{0, 35, 60, 10, 20, 45};
      bsr_pkg::req_type r;
      logic [31:0]      ins;
      logic [3:0]       rot;
      logic [4:0]       mode;
      for (int b = 0; b < blocks; b++) begin
         send_gap_pct = gap_levels[b % 6];
         stall_pct    = stall_levels[b % 6];
         for (int i = 0; i < per_block; i++) begin
            ins           = $urandom();
            r.action      = bsr_pkg::ACTION_MISC;
            r.pc_now      = $urandom();
            r.rm_value    = $urandom();
            r.cpsr_now    = $urandom();
            r.spsr_now    = $urandom();
            case ($urandom_range(5))
               0:       mode = bsr_pkg::MODE_USR;
               1:       mode = bsr_pkg::MODE_SYS;
               2:       mode = 5'h11;
               3:       mode = 5'h12;
               4:       mode = 5'h13;
               default: mode = 5'($urandom_range(31));
            endcase
            r.cpsr_now[4:0] = mode;
            case ($urandom_range(6))
               0: r.action = bsr_pkg::ACTION_BRANCH;
               1: begin
                  ins[27:20] = bsr_pkg::OP_BX_GROUP;
                  ins[7:4]   = bsr_pkg::OP_BLX_REG;
                  r.rm_value[0] = 1'($urandom_range(1));
               end
               2: begin
                  ins[27:23] = bsr_pkg::OP_PSR_REG;
                  ins[21:20] = bsr_pkg::OP_MRS_LOW;
               end
               3, 4: begin
                  ins[27:23] = bsr_pkg::OP_MSR_IMM;
                  ins[21:20] = bsr_pkg::OP_MSR_LOW;
                  // favor rotations that hit the user and privileged bytes
                  rot = 4'($urandom_range(15));
                  case ($urandom_range(3))
                     0: ins[11:8] = 4'h0;
                     1: ins[11:8] = 4'h2;
                     2: ins[11:8] = 4'h4;
                     default: ins[11:8] = rot;
                  endcase
               end
               5: begin
                  ins[27:23] = bsr_pkg::OP_PSR_REG;
                  ins[21:20] = bsr_pkg::OP_MSR_LOW;
                  ins[7:4]   = bsr_pkg::OP_MSR_SHIFT;
                  if ($urandom_range(3) != 0) r.rm_value &= ~bsr_pkg::MASK_UNALLOC;
                  if ($urandom_range(1) != 0) r.rm_value &= ~bsr_pkg::MASK_STATE;
               end
               default: ;   // noise: raw random word in the misc class
            endcase
            r.instruction = ins;
            send_item(r);
         end
         if (b == 1 || b == 4) wait_drained();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct = 20;
      stall_pct    = 20;
      test_branches();
      test_blx();
      test_mrs();
      test_msr_cpsr();
      test_msr_spsr();
      test_undefined();
      wait_drained();

      test_random_mix(6, 100);

      wait_drained();
      repeat (DRAIN_TAIL) @(posedge clock);

      $display("covered %0d transfers: %0d PC writes, %0d MRS, %0d CPSR and %0d SPSR writes,",
               n_transfers, n_pc_writes, n_rd_writes, n_cpsr, n_spsr);
      $display("  %0d undefined, %0d Thumb rejects, %0d mismatches in %0d cycles",
               n_undef, n_thumb, mismatches, cycle_count);
      if (mismatches == 0)
         $display("branch_and_status_register_execute regression: pass");
      else
         $display("branch_and_status_register_execute regression: fail");
      $finish;
   end

endmodule
